// File: rtl/aoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_pkg: shared types and constants of the alpha-over compositor
// Pixel and sideband types, the lane count and the default fraction width.
// ----------------------------------------------------------------------------
package aoc_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned NumLanes        = 3;

  typedef logic [7:0] byte_t;

  localparam byte_t ByteMax = 8'hFF;

  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t alpha;
  } rgba_t;

  typedef struct packed {
    logic pass_fg;
    logic pass_bg;
  } route_t;

  typedef struct packed {
    route_t route;
    rgba_t  fg;
    rgba_t  bg;
  } side_t;

endpackage

// File: rtl/aoc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_in_if: input pixel pair channel
// Valid/ready channel carrying one foreground and one background RGBA pixel.
// ----------------------------------------------------------------------------
interface aoc_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] fg_red;
  logic [7:0] fg_green;
  logic [7:0] fg_blue;
  logic [7:0] fg_alpha;
  logic [7:0] bg_red;
  logic [7:0] bg_green;
  logic [7:0] bg_blue;
  logic [7:0] bg_alpha;

  modport source (
    output valid, fg_red, fg_green, fg_blue, fg_alpha,
    output bg_red, bg_green, bg_blue, bg_alpha,
    input  ready
  );

  modport sink (
    input  valid, fg_red, fg_green, fg_blue, fg_alpha,
    input  bg_red, bg_green, bg_blue, bg_alpha,
    output ready
  );

endinterface

// File: rtl/aoc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_out_if: composited pixel channel
// Valid/ready channel carrying one composited RGBA pixel.
// ----------------------------------------------------------------------------
interface aoc_out_if;

  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );

endinterface

// File: rtl/aoc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_front: fraction conversion and premultiply pipeline
// Four stages: byte to fraction, first products, output alpha and second
// product, premultiplied sum per color lane.
// ----------------------------------------------------------------------------
module aoc_front
  import aoc_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  rgba_t                               fg_i,
  input  rgba_t                               bg_i,
  output logic                                valid_o,
  output side_t                               side_o,
  output logic [FracBits:0]                   oa_o,
  output logic [NumLanes-1:0][FracBits+1:0]   p_o
);

  localparam int unsigned FracW      = FracBits + 1;
  localparam int unsigned SumW       = FracBits + 2;
  localparam int unsigned NumStages  = 4;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipW     = FracBits + 9;
  localparam longint unsigned RecipFull =
    ((64'd1 << (FracBits + RecipShift)) + 64'd254) / 64'd255;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);
  localparam logic [FracW-1:0]  One   = {1'b1, {FracBits{1'b0}}};

  function automatic logic [FracW-1:0] to_frac(input byte_t x);
    logic [RecipW+7:0] prod;
    prod = {{RecipW{1'b0}}, x} * {8'd0, Recip};
    return prod[RecipShift +: FracW];
  endfunction

  function automatic logic [FracW-1:0] fx_mul(input logic [FracW-1:0] a,
                                              input logic [FracW-1:0] b);
    logic [2*FracW-1:0] prod;
    prod = {{FracW{1'b0}}, a} * {{FracW{1'b0}}, b};
    return prod[FracBits +: FracW];
  endfunction

  logic [NumStages-1:0] vld_q;
  side_t                side_q [NumStages];
  side_t                side_a;

  byte_t                fc [NumLanes];
  byte_t                bc [NumLanes];

  logic [FracW-1:0]     qfa_a_q, qba_a_q;
  logic [FracW-1:0]     qfc_a_q [NumLanes];
  logic [FracW-1:0]     qbc_a_q [NumLanes];

  logic [FracW-1:0]     inv_b_q, m1_b_q, qba_b_q;
  logic [FracW-1:0]     bcba_b_q [NumLanes];
  logic [FracW-1:0]     fcfa_b_q [NumLanes];

  logic [FracW:0]       oa_sum;
  logic [FracW-1:0]     oa_c_q;
  logic [FracW-1:0]     pbc_c_q  [NumLanes];
  logic [FracW-1:0]     fcfa_c_q [NumLanes];

  logic [FracW-1:0]     oa_d_q;
  logic [SumW-1:0]      p_d_q [NumLanes];

  always_comb begin
    fc = '{fg_i.red, fg_i.green, fg_i.blue};
    bc = '{bg_i.red, bg_i.green, bg_i.blue};
    side_a.fg = fg_i;
    side_a.bg = bg_i;
    side_a.route.pass_fg = (fg_i.alpha == ByteMax) || (bg_i.alpha == '0);
    side_a.route.pass_bg = (fg_i.alpha == '0);
    oa_sum = {1'b0, qba_b_q} + {1'b0, m1_b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_a;
      for (int s = 1; s < NumStages; s++) begin
        side_q[s] <= side_q[s-1];
      end

      qfa_a_q <= to_frac(fg_i.alpha);
      qba_a_q <= to_frac(bg_i.alpha);
      for (int l = 0; l < NumLanes; l++) begin
        qfc_a_q[l] <= to_frac(fc[l]);
        qbc_a_q[l] <= to_frac(bc[l]);
      end

      inv_b_q <= One - qfa_a_q;
      m1_b_q  <= fx_mul(qfa_a_q, One - qba_a_q);
      qba_b_q <= qba_a_q;
      for (int l = 0; l < NumLanes; l++) begin
        bcba_b_q[l] <= fx_mul(qbc_a_q[l], qba_a_q);
        fcfa_b_q[l] <= fx_mul(qfc_a_q[l], qfa_a_q);
      end

      oa_c_q <= (oa_sum > {1'b0, One}) ? One : oa_sum[FracW-1:0];
      for (int l = 0; l < NumLanes; l++) begin
        pbc_c_q[l]  <= fx_mul(bcba_b_q[l], inv_b_q);
        fcfa_c_q[l] <= fcfa_b_q[l];
      end

      oa_d_q <= oa_c_q;
      for (int l = 0; l < NumLanes; l++) begin
        p_d_q[l] <= {1'b0, pbc_c_q[l]} + {1'b0, fcfa_c_q[l]};
      end
    end
  end

  always_comb begin
    valid_o = vld_q[NumStages-1];
    side_o  = side_q[NumStages-1];
    oa_o    = oa_d_q;
    for (int l = 0; l < NumLanes; l++) begin
      p_o[l] = p_d_q[l];
    end
  end

  // a blended item always has nonzero output alpha
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-1] && !side_q[NumStages-1].route.pass_fg &&
    !side_q[NumStages-1].route.pass_bg |-> oa_d_q != '0)
    else $error("aoc_front: zero output alpha on a blended item");

endmodule

// File: rtl/aoc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_div: pipelined restoring divider, three lanes sharing one divisor
// Stage 0 flags quotients that saturate at one; each later stage resolves
// one quotient bit per lane. Sideband and divisor travel with the data.
// ----------------------------------------------------------------------------
module aoc_div
  import aoc_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault,
  parameter int unsigned SideW    = $bits(side_t)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [SideW-1:0]                    side_i,
  input  logic [FracBits:0]                   div_i,
  input  logic [NumLanes-1:0][FracBits+1:0]   num_i,
  output logic                                valid_o,
  output logic [SideW-1:0]                    side_o,
  output logic [FracBits:0]                   div_o,
  output logic [NumLanes-1:0]                 sat_o,
  output logic [NumLanes-1:0][FracBits-1:0]   quo_o
);

  localparam int unsigned Depth = FracBits + 1;
  localparam int unsigned FracW = FracBits + 1;
  localparam int unsigned RemW  = FracBits + 2;

  logic [Depth-1:0]    vld_q;
  logic [SideW-1:0]    side_q [Depth];
  logic [FracW-1:0]    div_q  [Depth];
  logic [NumLanes-1:0] sat_q  [Depth];
  logic [NumLanes-1:0] sat_d  [Depth];
  logic [RemW-1:0]     rem_q  [Depth][NumLanes];
  logic [RemW-1:0]     rem_d  [Depth][NumLanes];
  logic [FracBits-1:0] quo_q  [Depth][NumLanes];
  logic [FracBits-1:0] quo_d  [Depth][NumLanes];

  always_comb begin
    logic [RemW-1:0] shl;
    logic            take;
    for (int l = 0; l < NumLanes; l++) begin
      sat_d[0][l] = num_i[l] >= {1'b0, div_i};
      rem_d[0][l] = sat_d[0][l] ? '0 : num_i[l];
      quo_d[0][l] = '0;
    end
    for (int k = 1; k < Depth; k++) begin
      sat_d[k] = sat_q[k-1];
      for (int l = 0; l < NumLanes; l++) begin
        shl  = {rem_q[k-1][l][RemW-2:0], 1'b0};
        take = shl >= {1'b0, div_q[k-1]};
        rem_d[k][l] = take ? shl - {1'b0, div_q[k-1]} : shl;
        quo_d[k][l] = {quo_q[k-1][l][FracBits-2:0], take};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      div_q[0]  <= div_i;
      for (int k = 1; k < Depth; k++) begin
        side_q[k] <= side_q[k-1];
        div_q[k]  <= div_q[k-1];
      end
      sat_q <= sat_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    valid_o = vld_q[Depth-1];
    side_o  = side_q[Depth-1];
    div_o   = div_q[Depth-1];
    sat_o   = sat_q[Depth-1];
    for (int l = 0; l < NumLanes; l++) begin
      quo_o[l] = quo_q[Depth-1][l];
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_chk
    // partial remainder is below the divisor after the last step
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[Depth-1] && div_q[Depth-1] != '0 |->
      rem_q[Depth-1][l] < {1'b0, div_q[Depth-1]})
      else $error("aoc_div: remainder not below divisor");

    // saturated lanes start from a zero remainder and resolve no bits
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[Depth-1] && div_q[Depth-1] != '0 && sat_q[Depth-1][l] |->
      quo_q[Depth-1][l] == '0)
      else $error("aoc_div: saturated lane carries quotient bits");
  end

endmodule

// File: rtl/alpha_over_compositor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_over_compositor_top: source-over RGBA compositor
// Blends a foreground pixel over a background pixel, one pixel per clock while pix_o is not stalled.
//
//   port    dir   modport  payload
//   pix_i   in    sink     fg_red fg_green fg_blue fg_alpha
//                          bg_red bg_green bg_blue bg_alpha
//   pix_o   out   source   out_red out_green out_blue out_alpha
//
// Throughput is one pixel per cycle while pix_o does not stall; the path runs
// through the four-stage premultiply front, the
// FracBits + 1 stage bit-per-stage divider and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipeline holds while a result waits on pix_o, so pix_i.ready
// follows pix_o.ready combinationally whenever the output is occupied.
// ----------------------------------------------------------------------------
module alpha_over_compositor_top
  import aoc_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aoc_in_if.sink    pix_i,
  aoc_out_if.source pix_o
);

  localparam int unsigned FracW = FracBits + 1;
  localparam int unsigned SumW  = FracBits + 2;
  localparam int unsigned SideW = $bits(side_t);

  logic                            en;
  rgba_t                           fg, bg;

  logic                            fr_valid;
  side_t                           fr_side;
  logic [FracW-1:0]                fr_oa;
  logic [NumLanes-1:0][SumW-1:0]   fr_p;

  logic                            dv_valid;
  logic [SideW-1:0]                dv_side_raw;
  side_t                           dv_side;
  logic [FracW-1:0]                dv_oa;
  logic [NumLanes-1:0]             dv_sat;
  logic [NumLanes-1:0][FracBits-1:0] dv_quo;

  rgba_t                           res;
  logic                            out_vld_q;
  rgba_t                           out_q;

  assign en          = !out_vld_q || pix_o.ready;
  assign pix_i.ready = en;

  always_comb begin
    fg.red   = pix_i.fg_red;
    fg.green = pix_i.fg_green;
    fg.blue  = pix_i.fg_blue;
    fg.alpha = pix_i.fg_alpha;
    bg.red   = pix_i.bg_red;
    bg.green = pix_i.bg_green;
    bg.blue  = pix_i.bg_blue;
    bg.alpha = pix_i.bg_alpha;
  end

  aoc_front #(
    .FracBits (FracBits)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .fg_i    (fg),
    .bg_i    (bg),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .oa_o    (fr_oa),
    .p_o     (fr_p)
  );

  aoc_div #(
    .FracBits (FracBits),
    .SideW    (SideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .div_i   (fr_oa),
    .num_i   (fr_p),
    .valid_o (dv_valid),
    .side_o  (dv_side_raw),
    .div_o   (dv_oa),
    .sat_o   (dv_sat),
    .quo_o   (dv_quo)
  );

  assign dv_side = dv_side_raw;

  always_comb begin
    logic [FracBits+7:0] scaled;
    logic [FracBits+8:0] scaled_a;
    byte_t               lane_byte [NumLanes];
    rgba_t               blend;
    for (int l = 0; l < NumLanes; l++) begin
      scaled       = {dv_quo[l], 8'd0} - {8'd0, dv_quo[l]};
      lane_byte[l] = dv_sat[l] ? ByteMax : scaled[FracBits +: 8];
    end
    scaled_a    = {dv_oa, 8'd0} - {8'd0, dv_oa};
    blend.red   = lane_byte[0];
    blend.green = lane_byte[1];
    blend.blue  = lane_byte[2];
    blend.alpha = scaled_a[FracBits +: 8];
    if (dv_side.route.pass_fg) begin
      res = dv_side.fg;
    end else if (dv_side.route.pass_bg) begin
      res = dv_side.bg;
    end else begin
      res = blend;
    end
    if (res.alpha == '0) begin
      res.red   = '0;
      res.green = '0;
      res.blue  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign pix_o.valid     = out_vld_q;
  assign pix_o.out_red   = out_q.red;
  assign pix_o.out_green = out_q.green;
  assign pix_o.out_blue  = out_q.blue;
  assign pix_o.out_alpha = out_q.alpha;

  // zero coverage forces black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid && pix_o.out_alpha == '0 |->
    pix_o.out_red == '0 && pix_o.out_green == '0 && pix_o.out_blue == '0)
    else $error("top: color left on a zero-alpha result");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_o.valid |-> pix_i.ready)
    else $error("top: input stalled with empty output");

  // a finished divider item lands in the output register when advancing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid && en |=> pix_o.valid)
    else $error("top: result dropped between divider and output");

endmodule
